FILE: sv/mat4mf_pkg.sv
// ----------------------------------------------------------------------------
// mat4mf_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mat4mf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int ELEM_W          = 32;
  localparam int IDX_W           = 4;
  localparam int FRAC_W          = 5;
  localparam int PROD_W          = 2 * ELEM_W;
  localparam int ACC_W           = PROD_W + 2;
  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_LAST,
    ST_FIN,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_add;
    logic fin_en;
  } mac_ctrl_t;

endpackage

FILE: sv/mat4_multiply_fixed.sv
// ----------------------------------------------------------------------------
// mat4_multiply_fixed
// 4x4 signed fixed-point matrix product C = A * B, column-major elements.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction writes one element of A (tuser[0]=0) or B
//           (tuser[0]=1). With tuser[1] set, the product is computed after
//           the write and 16 out transactions follow, element 0 through 15.
//   out_* : tdata holds index and saturated value, tuser[0] the saturation
//           flag, tlast marks element 15.
//   cfg_* : writes frac_bits (reset 16); write only while idle.
// Sequencing: after the compute transaction is accepted, each element
//   steps through ST_MAC, ST_LAST, ST_FIN and then ST_OUT, where it is sent.
// Loads without compute are accepted back to back while idle. A compute
//   runs on one shared 32x32 multiply-accumulate: four multiplies, a final
//   add, a shift/saturate step and an output step per element, the output
//   step held until out_tready is high.
// in_tready is low for the whole compute. A stalled receiver holds the
//   current result; the sequencer waits on it.
// Reset clears both matrix stores and restores frac_bits to 16.
// ----------------------------------------------------------------------------
module mat4_multiply_fixed #(
  parameter int VALUE_WIDTH = mat4mf_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] element_index, [35:4] element_value
  input  logic [1:0]  in_tuser,   // [0] which_matrix, [1] compute_now
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] result_index, [35:4] result_value
  output logic [0:0]  out_tuser,  // [0] saturated
  output logic        out_tlast,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata   // [4:0] frac_bits
);

  localparam int IDX_W  = mat4mf_pkg::IDX_W;
  localparam int ELEM_W = mat4mf_pkg::ELEM_W;

  mat4mf_pkg::seq_state_t state_r, state_nxt;
  mat4mf_pkg::mac_ctrl_t  ctrl;

  logic [1:0]                     k_r, k_nxt;
  logic [IDX_W-1:0]               elem_r, elem_nxt;
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [mat4mf_pkg::FRAC_W-1:0]  frac_r;
  logic                           in_acc, out_acc;
  logic [ELEM_W-1:0]              op_a, op_b, res_value;
  logic                           res_sat;

  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid_r && out_tready;
  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= mat4mf_pkg::FRAC_RESET;
    end else if (cfg_tvalid) begin
      frac_r <= cfg_tdata[mat4mf_pkg::FRAC_W-1:0];
    end
  end

  mat4mf_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_acc),
    .wr_sel    (in_tuser[0]),
    .wr_idx    (in_tdata[IDX_W-1:0]),
    .wr_data   (in_tdata[IDX_W+ELEM_W-1:IDX_W]),
    .rd_idx_a  ({k_r, elem_r[1:0]}),
    .rd_idx_b  ({elem_r[3:2], k_r}),
    .rd_data_a (op_a),
    .rd_data_b (op_b)
  );

  mat4mf_mac #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mac (
    .clk       (clk),
    .ctrl      (ctrl),
    .op_a      (op_a),
    .op_b      (op_b),
    .frac      (frac_r),
    .res_value (res_value),
    .res_sat   (res_sat)
  );

  // next state
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    elem_nxt       = elem_r;
    out_tvalid_nxt = out_tvalid_r;
    case (state_r)
      mat4mf_pkg::ST_IDLE: begin
        if (in_acc && in_tuser[1]) begin
          state_nxt = mat4mf_pkg::ST_MAC;
          k_nxt     = '0;
          elem_nxt  = '0;
        end
      end
      mat4mf_pkg::ST_MAC: begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = mat4mf_pkg::ST_LAST;
        end
      end
      mat4mf_pkg::ST_LAST: begin
        state_nxt = mat4mf_pkg::ST_FIN;
      end
      mat4mf_pkg::ST_FIN: begin
        state_nxt      = mat4mf_pkg::ST_OUT;
        out_tvalid_nxt = 1'b1;
      end
      mat4mf_pkg::ST_OUT: begin
        if (out_acc) begin
          out_tvalid_nxt = 1'b0;
          k_nxt          = '0;
          if (elem_r == IDX_W'(15)) begin
            state_nxt = mat4mf_pkg::ST_IDLE;
          end else begin
            elem_nxt  = elem_r + IDX_W'(1);
            state_nxt = mat4mf_pkg::ST_MAC;
          end
        end
      end
      default: begin
        state_nxt      = mat4mf_pkg::ST_IDLE;
        out_tvalid_nxt = 1'b0;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl      = '0;
    in_tready = 1'b0;
    case (state_r)
      mat4mf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      mat4mf_pkg::ST_MAC: begin
        ctrl.mul_en  = 1'b1;
        ctrl.acc_clr = (k_r == 2'd0);
        ctrl.acc_add = (k_r != 2'd0);
      end
      mat4mf_pkg::ST_LAST: begin
        ctrl.acc_add = 1'b1;
      end
      mat4mf_pkg::ST_FIN: begin
        ctrl.fin_en = 1'b1;
      end
      mat4mf_pkg::ST_OUT: begin
        ctrl = '0;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mat4mf_pkg::ST_IDLE;
      k_r          <= '0;
      elem_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      elem_r       <= elem_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = {4'b0, res_value, elem_r};
  assign out_tuser[0] = res_sat;
  assign out_tlast    = (elem_r == IDX_W'(15));

endmodule

FILE: sv/mat4mf_store.sv
// ----------------------------------------------------------------------------
// mat4mf_store
// Left and right operand stores, 16 elements each, cleared on reset.
// ----------------------------------------------------------------------------
module mat4mf_store (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic                                  wr_sel,
  input  logic [mat4mf_pkg::IDX_W-1:0]          wr_idx,
  input  logic [mat4mf_pkg::ELEM_W-1:0]         wr_data,
  input  logic [mat4mf_pkg::IDX_W-1:0]          rd_idx_a,
  input  logic [mat4mf_pkg::IDX_W-1:0]          rd_idx_b,
  output logic [mat4mf_pkg::ELEM_W-1:0]         rd_data_a,
  output logic [mat4mf_pkg::ELEM_W-1:0]         rd_data_b
);

  localparam int DEPTH = 1 << mat4mf_pkg::IDX_W;

  logic [mat4mf_pkg::ELEM_W-1:0] left_r  [DEPTH];
  logic [mat4mf_pkg::ELEM_W-1:0] right_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        left_r[i]  <= '0;
        right_r[i] <= '0;
      end
    end else if (wr_en) begin
      if (wr_sel) begin
        right_r[wr_idx] <= wr_data;
      end else begin
        left_r[wr_idx] <= wr_data;
      end
    end
  end

  assign rd_data_a = left_r[rd_idx_a];
  assign rd_data_b = right_r[rd_idx_b];

endmodule

FILE: sv/mat4mf_mac.sv
// ----------------------------------------------------------------------------
// mat4mf_mac
// Shared multiply-accumulate unit with final arithmetic shift and saturation.
// ----------------------------------------------------------------------------
module mat4mf_mac #(
  parameter int VALUE_WIDTH = mat4mf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  mat4mf_pkg::mac_ctrl_t                 ctrl,
  input  logic [mat4mf_pkg::ELEM_W-1:0]         op_a,
  input  logic [mat4mf_pkg::ELEM_W-1:0]         op_b,
  input  logic [mat4mf_pkg::FRAC_W-1:0]         frac,
  output logic [mat4mf_pkg::ELEM_W-1:0]         res_value,
  output logic                                  res_sat
);

  localparam int ACC_W = mat4mf_pkg::ACC_W;
  localparam logic signed [ACC_W-1:0] MAXV =
    (ACC_W'(1) <<< (VALUE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);

  logic signed [mat4mf_pkg::PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]              acc_r;
  logic signed [ACC_W-1:0]              acc_nxt;
  logic signed [ACC_W-1:0]              shifted;
  logic [mat4mf_pkg::ELEM_W-1:0]        value_r;
  logic                                 sat_r;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= $signed(op_a) * $signed(op_b);
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctrl.acc_add) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign shifted = acc_r >>> frac;

  always_ff @(posedge clk) begin
    if (ctrl.fin_en) begin
      if (shifted > MAXV) begin
        value_r <= MAXV[mat4mf_pkg::ELEM_W-1:0];
        sat_r   <= 1'b1;
      end else if (shifted < MINV) begin
        value_r <= MINV[mat4mf_pkg::ELEM_W-1:0];
        sat_r   <= 1'b1;
      end else begin
        value_r <= shifted[mat4mf_pkg::ELEM_W-1:0];
        sat_r   <= 1'b0;
      end
    end
  end

  assign res_value = value_r;
  assign res_sat   = sat_r;

endmodule

FILE: sim/tb_mat4_multiply_fixed.sv
// ----------------------------------------------------------------------------
// tb_mat4_multiply_fixed
// Self-checking bench for the 4x4 fixed-point matrix multiplier. Element
// loads and compute requests are streamed in. A behavioral copy of both
// matrix stores predicts each product element. Every output transaction is
// checked in order against the predicted elements.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct {
  logic [3:0]  idx;
  logic [31:0] val;
  logic        sat;
  logic        last;
} product_elem_t;

class product_scoreboard;
  logic signed [31:0] left_m[16];
  logic signed [31:0] right_m[16];
  logic [4:0]         frac_bits;
  product_elem_t      product_q[$];

  function new();
    foreach (left_m[i]) begin
      left_m[i]  = '0;
      right_m[i] = '0;
    end
    frac_bits = mat4mf_pkg::FRAC_RESET;
  endfunction

  function void set_frac(logic [4:0] f);
    frac_bits = f;
  endfunction

  function int pending();
    return product_q.size();
  endfunction

  function void note_input(bit which, logic [3:0] idx, logic [31:0] val, bit compute);
    product_elem_t      e;
    logic signed [63:0] p;
    logic signed [65:0] acc;
    logic signed [65:0] shifted;
    if (which) right_m[idx] = val;
    else left_m[idx] = val;
    if (!compute) return;
    for (int n = 0; n < 16; n++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        p   = left_m[k * 4 + n % 4] * right_m[(n / 4) * 4 + k];
        acc = acc + p;
      end
      shifted = acc >>> frac_bits;
      e.idx  = 4'(n);
      e.last = (n == 15);
      if (shifted > 66'sd2147483647) begin
        e.val = 32'h7FFF_FFFF;
        e.sat = 1'b1;
      end else if (shifted < -66'sd2147483648) begin
        e.val = 32'h8000_0000;
        e.sat = 1'b1;
      end else begin
        e.val = shifted[31:0];
        e.sat = 1'b0;
      end
      product_q.push_back(e);
    end
  endfunction

  function string check_result(logic [3:0] idx, logic [31:0] val, logic sat, logic last);
    product_elem_t e;
    if (product_q.size() == 0)
      return $sformatf("unexpected element idx %0d val %h", idx, val);
    e = product_q.pop_front();
    if (idx !== e.idx || val !== e.val || sat !== e.sat || last !== e.last)
      return $sformatf("got idx %0d val %h sat %b last %b, want idx %0d val %h sat %b last %b",
                       idx, val, sat, last, e.idx, e.val, e.sat, e.last);
    return "";
  endfunction
endclass

module tb_mat4_multiply_fixed;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata;

  product_scoreboard sb;
  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;

  mat4_multiply_fixed uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_mat4_multiply_fixed: FAIL");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // receiver: random backpressure, with one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : result_monitor
    string msg;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        msg = sb.check_result(out_tdata[3:0], out_tdata[35:4], out_tuser[0], out_tlast);
        if (msg != "") report_mismatch(msg);
      end
    end
  end

  task automatic send_item(input bit which, input logic [3:0] idx, input logic [31:0] val,
                           input bit compute);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, val, idx};
    in_tuser  <= {compute, which};
    do @(posedge clk); while (!in_tready);
    sb.note_input(which, idx, val, compute);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_frac(input logic [4:0] f);
    wait_idle();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {3'b0, f};
    do @(posedge clk); while (!cfg_tready);
    sb.set_frac(f);
    cfg_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_elem(int f);
    logic [31:0] r;
    int          w;
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          default: return 32'h1 << f;
        endcase
      end
      default: begin
        w = (f + 2 > 31) ? 31 : f + 2;
        r = $urandom >> (32 - w);
        if ($urandom_range(1)) r = -r;
        return r;
      end
    endcase
  endfunction

  task automatic run_phase(input int s_pct, input int r_pct, input int n_items,
                           input bit with_hold);
    write_frac(5'($urandom_range(31)));
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == n_items / 3) hold_req = 1'b1;
      send_item(1'($urandom_range(1)), 4'($urandom_range(15)), rand_elem(sb.frac_bits),
                ($urandom_range(5) == 0));
    end
  endtask

  initial begin
    sb             = new();
    mismatch_count = 0;
    hold_req       = 1'b0;
    send_idle_pct  = 27;
    recv_idle_pct  = 83;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    cfg_tvalid <= 1'b0;
    cfg_tdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturation at both ends, reset frac_bits
    send_item(1'b0, 4'd0,  32'h7FFF_FFFF, 1'b0);
    send_item(1'b1, 4'd0,  32'h7FFF_FFFF, 1'b1);
    send_item(1'b0, 4'd15, 32'h8000_0000, 1'b0);
    send_item(1'b1, 4'd15, 32'h8000_0000, 1'b0);
    send_item(1'b0, 4'd12, 32'h7FFF_FFFF, 1'b1);
    send_item(1'b0, 4'd0,  32'h0001_0000, 1'b0);
    send_item(1'b0, 4'd15, 32'h0001_0000, 1'b0);
    send_item(1'b0, 4'd12, 32'h0000_0000, 1'b0);
    send_item(1'b0, 4'd5,  32'h0001_0000, 1'b0);
    send_item(1'b0, 4'd10, 32'h0001_0000, 1'b0);
    send_item(1'b1, 4'd0,  32'h0002_8000, 1'b0);
    send_item(1'b1, 4'd15, 32'hFFFF_8000, 1'b0);
    send_item(1'b1, 4'd7,  32'h1234_5678, 1'b0);
    send_item(1'b1, 4'd10, 32'hFFFF_FFFF, 1'b1);
    // no shift
    write_frac(5'd0);
    send_item(1'b0, 4'd3,  32'h0000_0003, 1'b0);
    send_item(1'b1, 4'd12, 32'hFFFF_FFFD, 1'b1);
    send_item(1'b0, 4'd1,  32'h8000_0000, 1'b1);
    // widest shift
    write_frac(5'd31);
    send_item(1'b0, 4'd1,  32'h7FFF_FFFF, 1'b0);
    send_item(1'b1, 4'd4,  32'h7FFF_FFFF, 1'b1);
    send_item(1'b1, 4'd8,  32'h8000_0000, 1'b1);

    run_phase(27, 83, 135, 1'b0);
    run_phase(83, 27, 135, 1'b0);
    run_phase(0, 0, 135, 1'b1);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_mat4_multiply_fixed: PASS");
    end else begin
      $display("tb_mat4_multiply_fixed: FAIL");
    end
    $finish;
  end

endmodule

FILE: mat4_multiply_fixed.f
sv/mat4mf_pkg.sv
sv/mat4mf_store.sv
sv/mat4mf_mac.sv
sv/mat4_multiply_fixed.sv
sim/tb_mat4_multiply_fixed.sv
